// ===== src/combined_lcg_shuffle_rng_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the combined LCG shuffle generator
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COMBINED_LCG_SHUFFLE_RNG_CORE_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLSR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent is a sequence that starts in the cycle after the antecedent.
`define CLSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error(msg);

`endif

// ===== src/clsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Combined LCG shuffle generator package
// Widths, generator constants and the structs between controller and datapath.
// ----------------------------------------------------------------------------
package clsr_pkg;

   localparam int VALUE_W         = 31;
   localparam int MUL_W           = 16;
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int WARM_EXTRA      = 8;

   localparam logic [VALUE_W:0]   MOD_ONE = 32'd2147483563;
   localparam logic [VALUE_W:0]   MOD_TWO = 32'd2147483399;
   localparam logic [MUL_W-1:0]   MUL_ONE = 16'd40014;
   localparam logic [MUL_W-1:0]   MUL_TWO = 16'd40692;
   localparam logic [VALUE_W-1:0] TOP_VALUE      = 31'd2147483562;
   localparam logic [VALUE_W-1:0] GEN_ONE_RESET  = 31'd1;
   localparam logic [VALUE_W-1:0] GEN_TWO_RESET  = 31'd123456789;

   typedef struct packed {
      logic seed_load;
      logic gen_one_step;
      logic gen_two_step;
      logic warm_write;
      logic slot_capture;
      logic mix;
   } clsr_cmd_type;

   typedef struct packed {
      logic warm_last;
   } clsr_sts_type;

endpackage

// ===== src/clsr_if.sv =====
// ----------------------------------------------------------------------------
// Combined LCG shuffle generator channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface clsr_req_if
   import clsr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [VALUE_W-1:0] seed_value;

   modport source (output valid, output operation, output seed_value, input ready);
   modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface clsr_rsp_if
   import clsr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] random_value;

   modport source (output valid, output random_value, input ready);
   modport sink   (input valid, input random_value, output ready);
endinterface

// ===== src/clsr_mcg.sv =====
// ----------------------------------------------------------------------------
// Multiplicative congruential step
// Three-stage multiply, fold and reduce unit computing (value * MUL) mod MOD.
// ----------------------------------------------------------------------------
module clsr_mcg
   import clsr_pkg::*;
#(
   parameter logic [MUL_W-1:0] MUL = MUL_ONE,
   parameter logic [VALUE_W:0] MOD = MOD_ONE
) (
   input  logic               clock,
   input  logic [VALUE_W-1:0] value,
   output logic [VALUE_W-1:0] result
);

   localparam int PROD_W = VALUE_W + MUL_W;
   localparam int SUM_W  = VALUE_W + 1;
   // The modulus sits just below 2^31, so 2^31 folds back as this small residue.
   localparam logic [SUM_W-1:0] FOLD = (SUM_W'(1) << VALUE_W) - MOD;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   assign prod_in = PROD_W'(value) * PROD_W'(MUL);
   // The folded sum stays below twice the modulus, so one subtract finishes it.
   assign sum_in  = SUM_W'(prod_ff[PROD_W-1:VALUE_W]) * FOLD
                  + SUM_W'(prod_ff[VALUE_W-1:0]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   always_comb begin
      if (sum_ff >= MOD) begin
         result = VALUE_W'(sum_ff - MOD);
      end else begin
         result = sum_ff[VALUE_W-1:0];
      end
   end

endmodule

// ===== src/clsr_dpath.sv =====
// ----------------------------------------------------------------------------
// Combined LCG shuffle generator datapath
// Generator registers, shuffle table, slot selection and output mixing.
// ----------------------------------------------------------------------------
module clsr_dpath
   import clsr_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  clsr_cmd_type       cmd,
   output clsr_sts_type       sts,
   input  logic [VALUE_W-1:0] seed_value,
   output logic [VALUE_W-1:0] random_value
);

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int CW     = $clog2(TABLE_DEPTH + WARM_EXTRA);
   localparam int PROD_W = 2 * VALUE_W + 1;
   localparam logic [VALUE_W-1:0] SLOT_DIV = TOP_VALUE / VALUE_W'(TABLE_DEPTH) + 1'b1;
   localparam int DIV_LOG = $clog2(SLOT_DIV);
   localparam int SHIFT   = VALUE_W + DIV_LOG;
   // Rounded-up reciprocal; with this shift the quotient is exact for any 31-bit value.
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(SLOT_DIV) - 64'd1) / 64'(SLOT_DIV);
   localparam logic [VALUE_W:0] RECIP = RECIP_WIDE[VALUE_W:0];

   logic [VALUE_W-1:0] gen_one_ff, gen_one_in;
   logic [VALUE_W-1:0] gen_two_ff, gen_two_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic [VALUE_W-1:0] out_ff, out_in;
   logic [CW-1:0]      warm_cnt_ff, warm_cnt_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [PROD_W-1:0]  recip_prod_ff;
   logic [PROD_W-1:0]  quot;
   logic [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [VALUE_W-1:0] rdata_ff;
   logic               rvalid_ff;
   logic [VALUE_W-1:0] slot_value;
   logic [VALUE_W-1:0] seed_clamped;
   logic [VALUE_W-1:0] mcg_one_res, mcg_two_res;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [VALUE_W:0]   diff, mixed;

   clsr_mcg #(.MUL(MUL_ONE), .MOD(MOD_ONE)) u_mcg_one (
      .clock  (clock),
      .value  (gen_one_ff),
      .result (mcg_one_res)
   );

   clsr_mcg #(.MUL(MUL_TWO), .MOD(MOD_TWO)) u_mcg_two (
      .clock  (clock),
      .value  (gen_two_ff),
      .result (mcg_two_res)
   );

   assign seed_clamped = (seed_value == '0) ? GEN_ONE_RESET : seed_value;
   assign sts.warm_last = (warm_cnt_ff == '0);

   // Slot index: quotient of the last output by the slot width, saturated.
   assign quot    = recip_prod_ff >> SHIFT;
   assign slot_in = (quot >= PROD_W'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1) : quot[AW-1:0];

   assign slot_value = rvalid_ff ? rdata_ff : '0;
   assign diff  = {1'b0, slot_value} - {1'b0, gen_two_ff};
   assign mixed = (diff[VALUE_W] || diff == '0) ? diff + {1'b0, TOP_VALUE} : diff;

   always_comb begin
      gen_one_in  = gen_one_ff;
      gen_two_in  = gen_two_ff;
      last_in     = last_ff;
      out_in      = out_ff;
      warm_cnt_in = warm_cnt_ff;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = gen_one_ff;
      if (cmd.seed_load) begin
         gen_one_in  = seed_clamped;
         gen_two_in  = seed_clamped;
         warm_cnt_in = CW'(TABLE_DEPTH + WARM_EXTRA - 1);
      end
      if (cmd.gen_one_step) begin
         gen_one_in = mcg_one_res;
      end
      if (cmd.gen_two_step) begin
         gen_two_in = mcg_two_res;
      end
      if (cmd.warm_write) begin
         warm_cnt_in = warm_cnt_ff - 1'b1;
         // Only the last TABLE_DEPTH warm-up steps land in the table.
         if (warm_cnt_ff < CW'(TABLE_DEPTH)) begin
            wr_en   = 1'b1;
            wr_addr = warm_cnt_ff[AW-1:0];
            wr_data = mcg_one_res;
         end
         if (warm_cnt_ff == '0) begin
            last_in = mcg_one_res;
         end
      end
      if (cmd.mix) begin
         wr_en   = 1'b1;
         last_in = mixed[VALUE_W-1:0];
         out_in  = mixed[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_one_ff <= GEN_ONE_RESET;
         gen_two_ff <= GEN_TWO_RESET;
         last_ff    <= '0;
         valid_ff   <= '0;
      end else begin
         gen_one_ff <= gen_one_in;
         gen_two_ff <= gen_two_in;
         last_ff    <= last_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      warm_cnt_ff   <= warm_cnt_in;
      out_ff        <= out_in;
      recip_prod_ff <= PROD_W'(last_ff) * PROD_W'(RECIP);
      if (cmd.slot_capture) begin
         slot_ff <= slot_in;
      end
   end

   // Shuffle table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff  <= mem[slot_ff];
      rvalid_ff <= valid_ff[slot_ff];
   end

   assign random_value = out_ff;

endmodule

// ===== src/clsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Combined LCG shuffle generator controller
// Sequences warm-up and draw steps and owns the response valid flag.
// ----------------------------------------------------------------------------
module clsr_ctrl
   import clsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_operation,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output clsr_cmd_type cmd,
   input  clsr_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WARM_MUL,
      ST_WARM_FOLD,
      ST_WARM_RED,
      ST_DRAW_MUL,
      ST_DRAW_FOLD,
      ST_DRAW_RED,
      ST_DRAW_MIX
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.seed_load = req_operation;
               state_in      = req_operation ? ST_WARM_MUL : ST_DRAW_MUL;
            end
         end
         ST_WARM_MUL: begin
            state_in = ST_WARM_FOLD;
         end
         ST_WARM_FOLD: begin
            state_in = ST_WARM_RED;
         end
         ST_WARM_RED: begin
            cmd.gen_one_step = 1'b1;
            cmd.warm_write   = 1'b1;
            state_in         = sts.warm_last ? ST_DRAW_MUL : ST_WARM_MUL;
         end
         ST_DRAW_MUL: begin
            state_in = ST_DRAW_FOLD;
         end
         ST_DRAW_FOLD: begin
            cmd.slot_capture = 1'b1;
            state_in         = ST_DRAW_RED;
         end
         ST_DRAW_RED: begin
            cmd.gen_one_step = 1'b1;
            cmd.gen_two_step = 1'b1;
            state_in         = ST_DRAW_MIX;
         end
         ST_DRAW_MIX: begin
            // Wait here while the previous result still sits unread.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.mix      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/combined_lcg_shuffle_rng_core.sv =====
// ----------------------------------------------------------------------------
// Combined LCG shuffle generator
// Two-generator congruential source with a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Each request beat asks for one draw (operation 0) or for a reseed from
// seed_value followed by one draw (operation 1). Every request gives exactly
// one response beat carrying random_value in [1, 2147483562], which stands
// for the fraction random_value / 2147483563.
// A draw after the request beat runs multiply, fold and reduce in the two
// generator units, then the table read resolves and the result is mixed
// into the output register. A new request is taken only in the idle state,
// once the previous draw has been mixed.
// A reseed first runs TABLE_DEPTH + 8 warm-up steps of the first generator,
// each through multiply, fold and reduce, filling the table, and then draws.
// The response sits in an output register, so a stalled receiver only holds
// the block once the next result is ready to be written.
// Reset loads the generators with 1 and 123456789, clears the last output
// and marks every table entry as zero; the block is ready at once.
// ----------------------------------------------------------------------------
`include "combined_lcg_shuffle_rng_core_macros.svh"

module combined_lcg_shuffle_rng_core
   import clsr_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   clsr_req_if.sink          req_bus,
   clsr_rsp_if.source        rsp_bus
);

   clsr_cmd_type cmd;
   clsr_sts_type sts;

   clsr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .cmd           (cmd),
      .sts           (sts)
   );

   clsr_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .seed_value   (req_bus.seed_value),
      .random_value (rsp_bus.random_value)
   );

   `CLSR_ASSERT_SAME(a_rsp_range, clock, reset, rsp_bus.valid, rsp_bus.random_value != '0 && rsp_bus.random_value <= TOP_VALUE, "response value out of range")
   `CLSR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "request taken while a beat is in work")
   `CLSR_ASSERT_NEXT(a_reseed_warms, clock, reset, req_bus.valid && req_bus.ready && req_bus.operation, ##4 !req_bus.ready, "reseed skipped the warm-up")

endmodule
